// ----- rtl/ilir_pkg.sv -----
// Shared types, codes and constants for the indexed list block.
`timescale 1ns / 1ps

package ilir_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned POS_W        = 8;
    localparam int unsigned KIND_W       = 3;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned COUNT_W      = 9;
    localparam int unsigned SLOT_W       = 12;   // covers every cell up to 4096
    localparam int unsigned GRP          = 16;   // cells per first-level read-out group
    localparam int unsigned DEF_CAPACITY = 256;
    localparam int unsigned S_TDATA_W    = 48;
    localparam int unsigned M_TDATA_W    = 48;

    typedef enum logic [KIND_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_INSERT     = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_POP_FRONT  = 3'd4,
        REQ_REMOVE     = 3'd5,
        REQ_GET        = 3'd6,
        REQ_SET        = 3'd7
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SEL  = 2'd1,
        S_EXE  = 2'd2
    } state_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              wr;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
    } cell_ctl_t;

endpackage

// ----- rtl/ilir_cell.sv -----
// One storage cell of the list row: holds one element and trades with its neighbors.
`timescale 1ns / 1ps

module ilir_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                      aclk,
    input  ilir_pkg::cell_ctl_t       ctl,
    input  logic [ilir_pkg::WORD_W-1:0] left_data,
    input  logic [ilir_pkg::WORD_W-1:0] right_data,
    output logic [ilir_pkg::WORD_W-1:0] data,
    output logic [ilir_pkg::WORD_W-1:0] rd_data
);

    localparam logic [ilir_pkg::SLOT_W-1:0] MY_SLOT = ilir_pkg::SLOT_W'(INDEX);

    logic [ilir_pkg::WORD_W-1:0] data_reg;
    logic [ilir_pkg::WORD_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (MY_SLOT > ctl.slot) begin
                data_next = left_data;
            end else if (MY_SLOT == ctl.slot) begin
                data_next = ctl.word;
            end
        end else if (ctl.rem) begin
            if (MY_SLOT >= ctl.slot) begin
                data_next = right_data;
            end
        end else if (ctl.wr) begin
            if (MY_SLOT == ctl.slot) begin
                data_next = ctl.word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // Drive the word only when addressed so the read-out can OR all cells.
    assign rd_data = (MY_SLOT == ctl.slot) ? data_reg : '0;

endmodule

// ----- rtl/indexed_list_insert_remove.sv -----
// Top level of the indexed list: request decode, cell row, read-out tree and result register.
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit words held in a row of CAPACITY cells.
// Each request (push back/front, insert at, pop back/front, remove at, get, set)
// returns exactly one result beat with a status, the word read and the element
// count after the request. A request runs in order: the beat is accepted, then
// the addressed cell's word is gathered through a two-level OR tree (groups of
// 16 cells, registered), then every cell shifts, writes or holds at once while
// the result loads into the output register; this last step waits while the
// output register holds a result not yet taken. The next beat is accepted only
// after that load. s_tready is high only while no request is in progress, and a
// finished result may wait in the output register while the next beat is taken.
// Storage is not cleared by reset; only positions below the count are ever read.

module indexed_list_insert_remove #(
    parameter int unsigned CAPACITY = ilir_pkg::DEF_CAPACITY
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // req_type[2:0], position[10:3], value_in[42:11], zero fill above
    input  logic [ilir_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], value_out[33:2], count[42:34], zero fill above
    output logic [ilir_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CNT_W > ilir_pkg::POS_W) ? CNT_W : ilir_pkg::POS_W;
    localparam int unsigned NGRP  = (CAPACITY + ilir_pkg::GRP - 1) / ilir_pkg::GRP;
    localparam int unsigned WW    = ilir_pkg::WORD_W;

    // Control state.
    ilir_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_tvalid_reg;

    // Captured request (payload, no reset).
    ilir_pkg::req_kind_t           kind_reg;
    logic [ilir_pkg::POS_W-1:0]    pos_reg;
    logic [WW-1:0]                 word_reg;

    // Result register payload.
    ilir_pkg::status_t             status_out_reg;
    logic [WW-1:0]                 value_out_reg;
    logic [ilir_pkg::COUNT_W-1:0]  count_out_reg;

    // Decode results.
    ilir_pkg::status_t  status_dec;
    logic               ins_dec, rem_dec, wr_dec, rd_dec;
    logic [ilir_pkg::SLOT_W-1:0] slot_dec;
    logic               full, empty, in_range;

    // FSM outputs.
    logic out_free, sel_en, exe_go;

    ilir_pkg::cell_ctl_t ctl;
    logic [WW-1:0] cell_data [CAPACITY];
    logic [WW-1:0] cell_rd   [CAPACITY];
    logic [WW-1:0] grp_or    [NGRP];
    logic [WW-1:0] grp_reg   [NGRP];
    logic [WW-1:0] read_word;

    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ilir_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = ilir_pkg::S_SEL;
                end
            end
            ilir_pkg::S_SEL: begin
                state_next = ilir_pkg::S_EXE;
            end
            ilir_pkg::S_EXE: begin
                // Hold until the result register can take the beat.
                if (out_free) begin
                    state_next = ilir_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ilir_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_tready = 1'b0;
        sel_en   = 1'b0;
        exe_go   = 1'b0;
        case (state_reg)
            ilir_pkg::S_IDLE: begin
                s_tready = 1'b1;
            end
            ilir_pkg::S_SEL: begin
                sel_en = 1'b1;
            end
            ilir_pkg::S_EXE: begin
                exe_go = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ilir_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the request beat.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg <= ilir_pkg::req_kind_t'(s_tdata[2:0]);
            pos_reg  <= s_tdata[10:3];
            word_reg <= s_tdata[42:11];
        end
    end

    // ---------------------------------------------------------------
    // Request decode: status, cell action and addressed slot
    // ---------------------------------------------------------------
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign in_range = (CMP_W'(pos_reg) < CMP_W'(count_reg));

    always_comb begin
        status_dec = ilir_pkg::STAT_OK;
        ins_dec    = 1'b0;
        rem_dec    = 1'b0;
        wr_dec     = 1'b0;
        rd_dec     = 1'b0;
        slot_dec   = ilir_pkg::SLOT_W'(pos_reg);
        case (kind_reg)
            ilir_pkg::REQ_PUSH_BACK: begin
                slot_dec = ilir_pkg::SLOT_W'(count_reg);
                if (full) begin
                    status_dec = ilir_pkg::STAT_FULL;
                end else begin
                    ins_dec = 1'b1;
                end
            end
            ilir_pkg::REQ_PUSH_FRONT: begin
                slot_dec = '0;
                if (full) begin
                    status_dec = ilir_pkg::STAT_FULL;
                end else begin
                    ins_dec = 1'b1;
                end
            end
            ilir_pkg::REQ_INSERT: begin
                // Index check ranks ahead of the full check.
                if (!in_range) begin
                    status_dec = ilir_pkg::STAT_INVALID;
                end else if (full) begin
                    status_dec = ilir_pkg::STAT_FULL;
                end else begin
                    ins_dec = 1'b1;
                end
            end
            ilir_pkg::REQ_POP_BACK: begin
                slot_dec = ilir_pkg::SLOT_W'(count_reg - CNT_W'(1));
                if (empty) begin
                    status_dec = ilir_pkg::STAT_EMPTY;
                end else begin
                    rem_dec = 1'b1;
                    rd_dec  = 1'b1;
                end
            end
            ilir_pkg::REQ_POP_FRONT: begin
                slot_dec = '0;
                if (empty) begin
                    status_dec = ilir_pkg::STAT_EMPTY;
                end else begin
                    rem_dec = 1'b1;
                    rd_dec  = 1'b1;
                end
            end
            ilir_pkg::REQ_REMOVE: begin
                if (!in_range) begin
                    status_dec = ilir_pkg::STAT_INVALID;
                end else begin
                    rem_dec = 1'b1;
                    rd_dec  = 1'b1;
                end
            end
            ilir_pkg::REQ_GET: begin
                if (!in_range) begin
                    status_dec = ilir_pkg::STAT_INVALID;
                end else begin
                    rd_dec = 1'b1;
                end
            end
            ilir_pkg::REQ_SET: begin
                if (!in_range) begin
                    status_dec = ilir_pkg::STAT_INVALID;
                end else begin
                    wr_dec = 1'b1;
                end
            end
            default: begin
                status_dec = ilir_pkg::STAT_INVALID;
            end
        endcase
    end

    // Cells act only in the execute cycle; the slot is held steady from select on.
    always_comb begin
        ctl.ins  = exe_go && ins_dec;
        ctl.rem  = exe_go && rem_dec;
        ctl.wr   = exe_go && wr_dec;
        ctl.slot = slot_dec;
        ctl.word = word_reg;
    end

    // ---------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WW-1:0] left_w;
        logic [WW-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_w = cell_data[i];
        end else begin : g_mid_r
            assign right_w = cell_data[i+1];
        end
        ilir_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // ---------------------------------------------------------------
    // Read-out tree: OR each group of cells, register, then OR the groups
    // ---------------------------------------------------------------
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_or[g] = '0;
            for (int k = 0; k < ilir_pkg::GRP; k++) begin
                if (g * ilir_pkg::GRP + k < CAPACITY) begin
                    grp_or[g] = grp_or[g] | cell_rd[g * ilir_pkg::GRP + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sel_en) begin
            for (int g = 0; g < NGRP; g++) begin
                grp_reg[g] <= grp_or[g];
            end
        end
    end

    always_comb begin
        read_word = '0;
        for (int g = 0; g < NGRP; g++) begin
            read_word = read_word | grp_reg[g];
        end
    end

    // ---------------------------------------------------------------
    // Element count
    // ---------------------------------------------------------------
    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.rem) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exe_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exe_go) begin
            status_out_reg <= status_dec;
            value_out_reg  <= rd_dec ? read_word : '0;
            count_out_reg  <= ilir_pkg::COUNT_W'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, count_out_reg, value_out_reg, status_out_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_full_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (exe_go && status_dec == ilir_pkg::STAT_FULL) |=> $stable(count_reg))
        else $error("count moved on a rejected push");

    a_accept_to_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ilir_pkg::S_SEL))
        else $error("accepted beat did not start read-out");

    a_result_from_exe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ilir_pkg::S_EXE))
        else $error("result appeared outside execute");

    a_fail_zero_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (exe_go && status_dec != ilir_pkg::STAT_OK) |=> (value_out_reg == '0))
        else $error("failed request returned a nonzero word");

endmodule

// ----- bench/indexed_list_checker.sv -----
// Checker for the indexed list: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps

module indexed_list_checker #(
    parameter int unsigned CAPACITY = ilir_pkg::DEF_CAPACITY
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ilir_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ilir_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                              fail_count,
    output int                              pending,
    output logic [ilir_pkg::COUNT_W-1:0]    list_len,
    output int                              full_refusals,
    output int                              empty_refusals,
    output int                              index_refusals
);
    import ilir_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [WORD_W-1:0]   word;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    logic [WORD_W-1:0]  cells [CAPACITY];
    logic [COUNT_W-1:0] held;
    list_result_t       list_results_due [$];
    list_result_t       due;
    int                 mismatches;
    int                 results_checked;
    int                 n_full, n_empty, n_index;

    task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        $display("checker: result %0d %s: got %h, want %h",
                 results_checked, what, got, want);
        mismatches++;
    endtask

    function automatic void open_slot(input int unsigned slot, input logic [WORD_W-1:0] w);
        for (int i = int'(held); i > int'(slot); i--)
            cells[i] = cells[i-1];
        cells[slot] = w;
        held++;
    endfunction

    function automatic logic [WORD_W-1:0] close_slot(input int unsigned slot);
        logic [WORD_W-1:0] w;
        w = cells[slot];
        for (int i = int'(slot) + 1; i < int'(held); i++)
            cells[i-1] = cells[i];
        held--;
        return w;
    endfunction

    // Apply one request to the shadow list and queue the result it owes.
    task automatic apply_list_request(input req_kind_t kind, input logic [POS_W-1:0] pos,
                                      input logic [WORD_W-1:0] word);
        list_result_t r;
        logic         full;
        logic         in_range;
        full     = (held >= CAPACITY);
        in_range = (pos < held);
        r.status = STAT_OK;
        r.word   = '0;
        case (kind)
            REQ_PUSH_BACK: begin
                if (full) r.status = STAT_FULL;
                else open_slot(held, word);
            end
            REQ_PUSH_FRONT: begin
                if (full) r.status = STAT_FULL;
                else open_slot(0, word);
            end
            REQ_INSERT: begin
                if (!in_range) r.status = STAT_INVALID;
                else if (full) r.status = STAT_FULL;
                else open_slot(pos, word);
            end
            REQ_POP_BACK: begin
                if (held == 0) r.status = STAT_EMPTY;
                else r.word = close_slot(held - 1);
            end
            REQ_POP_FRONT: begin
                if (held == 0) r.status = STAT_EMPTY;
                else r.word = close_slot(0);
            end
            REQ_REMOVE: begin
                if (!in_range) r.status = STAT_INVALID;
                else r.word = close_slot(pos);
            end
            REQ_GET: begin
                if (!in_range) r.status = STAT_INVALID;
                else r.word = cells[pos];
            end
            default: begin
                if (!in_range) r.status = STAT_INVALID;
                else cells[pos] = word;
            end
        endcase
        r.count = held;
        case (r.status)
            STAT_FULL:    n_full++;
            STAT_EMPTY:   n_empty++;
            STAT_INVALID: n_index++;
            default: ;
        endcase
        list_results_due.insert(list_results_due.size(), r);
    endtask

    initial begin
        held            = '0;
        mismatches      = 0;
        results_checked = 0;
        n_full          = 0;
        n_empty         = 0;
        n_index         = 0;
        fail_count      = 0;
        pending         = 0;
        list_len        = '0;
        full_refusals   = 0;
        empty_refusals  = 0;
        index_refusals  = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            held = '0;
            list_results_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                apply_list_request(req_kind_t'(s_tdata[2:0]), s_tdata[10:3], s_tdata[42:11]);
            if (m_tvalid && m_tready) begin
                if (list_results_due.size() == 0) begin
                    flag_mismatch("beat with nothing owed", m_tdata[33:2], '0);
                end else begin
                    due = list_results_due[0];
                    list_results_due.delete(0);
                    if (m_tdata[1:0] != due.status)
                        flag_mismatch("status", WORD_W'(m_tdata[1:0]), WORD_W'(due.status));
                    if (m_tdata[33:2] != due.word)
                        flag_mismatch("value_out", m_tdata[33:2], due.word);
                    if (m_tdata[42:34] != due.count)
                        flag_mismatch("count", WORD_W'(m_tdata[42:34]), WORD_W'(due.count));
                end
                results_checked++;
            end
        end
        fail_count     <= mismatches;
        pending        <= list_results_due.size();
        list_len       <= held;
        full_refusals  <= n_full;
        empty_refusals <= n_empty;
        index_refusals <= n_index;
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the indexed list: clock, reset, request and result drivers, verdict.
`timescale 1ns / 1ps

module tb;
    import ilir_pkg::*;

    localparam int unsigned LIST_CAP    = DEF_CAPACITY;
    localparam int          ITEMS       = 950;
    localparam int          LONG_HOLD   = 300;   // cycles the result side refuses beats once
    localparam int          STALL_LIMIT = 4000;  // cycles without any beat before giving up
    localparam int          DRAIN_TAIL  = 20;    // cycles of settling after the last result is back

    typedef enum logic [1:0] {
        MIX_ANY    = 2'd0,
        MIX_GROW   = 2'd1,
        MIX_SHRINK = 2'd2
    } mix_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // req_type[2:0], position[10:3], value_in[42:11], zero fill above
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // status[1:0], value_out[33:2], count[42:34], zero fill above
    logic [M_TDATA_W-1:0]  m_tdata;

    int                    fail_count;
    int                    pending;
    logic [COUNT_W-1:0]    list_len;
    int                    full_refusals, empty_refusals, index_refusals;

    int                    requests_sent;
    int                    results_taken;
    int                    cycles_run;
    int                    idle_cycles;
    int                    peak_len;
    logic                  hold_sink;

    indexed_list_insert_remove #(.CAPACITY(LIST_CAP)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    indexed_list_checker #(.CAPACITY(LIST_CAP)) chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .list_len       (list_len),
        .full_refusals  (full_refusals),
        .empty_refusals (empty_refusals),
        .index_refusals (index_refusals)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Count beats and cycles; end the run if neither channel moves for too long.
    initial begin
        requests_sent = 0;
        results_taken = 0;
        cycles_run    = 0;
        idle_cycles   = 0;
    end

    always @(posedge aclk) begin
        cycles_run <= cycles_run + 1;
        if (s_tvalid && s_tready)
            requests_sent <= requests_sent + 1;
        if (m_tvalid && m_tready)
            results_taken <= results_taken + 1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: no beat for %0d cycles, %0d results still owed",
                     idle_cycles, pending);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: wait a random number of cycles before each beat, with quiet
    // stretches of back-to-back acceptance, and one long hold on request.
    initial begin : result_sink
        int gap;
        int quiet_left;
        m_tready   = 1'b0;
        quiet_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                gap       = LONG_HOLD;
                hold_sink = 1'b0;
            end else if (quiet_left != 0) begin
                gap = 0;
                quiet_left--;
            end else begin
                if ($urandom_range(0, 24) == 0)
                    quiet_left = $urandom_range(10, 40);
                gap = $urandom_range(0, 13);
            end
            if (gap != 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Request side gap; returns at the falling edge where the next beat goes out.
    int src_quiet_left = 0;

    task automatic source_gap();
        int gap;
        @(negedge aclk);
        if (src_quiet_left != 0) begin
            gap = 0;
            src_quiet_left--;
        end else begin
            if ($urandom_range(0, 24) == 0)
                src_quiet_left = $urandom_range(10, 40);
            gap = $urandom_range(0, 13);
        end
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Present one request beat and hold it until the block takes it.
    task automatic offer(input req_kind_t kind, input logic [POS_W-1:0] pos,
                         input logic [WORD_W-1:0] word);
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W - KIND_W - POS_W - WORD_W){1'b0}}, word, pos, kind};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic send_fixed(input req_kind_t kind, input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] word);
        source_gap();
        offer(kind, pos, word);
    endtask

    // Pick a request biased toward growing or shrinking the list; positions
    // mostly land inside the list, some just past the end, some anywhere.
    task automatic send_random(input mix_t mix);
        req_kind_t          kind;
        logic [POS_W-1:0]   pos;
        logic [WORD_W-1:0]  word;
        int                 roll;
        source_gap();
        if (int'(list_len) > peak_len)
            peak_len = list_len;
        roll = $urandom_range(0, 99);
        if (mix == MIX_GROW && roll < 80) begin
            case ($urandom_range(0, 2))
                0:       kind = REQ_PUSH_BACK;
                1:       kind = REQ_PUSH_FRONT;
                default: kind = REQ_INSERT;
            endcase
        end else if (mix == MIX_SHRINK && roll < 80) begin
            case ($urandom_range(0, 2))
                0:       kind = REQ_POP_BACK;
                1:       kind = REQ_POP_FRONT;
                default: kind = REQ_REMOVE;
            endcase
        end else begin
            kind = req_kind_t'($urandom_range(REQ_PUSH_BACK, REQ_SET));
        end
        roll = $urandom_range(0, 99);
        if (list_len != 0 && roll < 80)
            pos = $urandom_range(0, list_len - 1);
        else if (roll < 90)
            pos = list_len[POS_W-1:0];
        else
            pos = $urandom_range(0, 255);
        case ($urandom_range(0, 15))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7FFF_FFFF;
            2:       word = 32'h0000_0000;
            3:       word = 32'hFFFF_FFFF;
            default: word = $urandom;
        endcase
        offer(kind, pos, word);
    endtask

    // Stop sending until every owed result is back.
    task automatic drain_wait();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin : stimulus
        int sent;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        hold_sink = 1'b0;
        peak_len  = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: refusals on an empty list, extreme words, insert at the
        // last slot and just past it, get/set/remove in and out of range.
        send_fixed(REQ_POP_BACK,   8'h00, 32'h0000_0000);
        send_fixed(REQ_POP_FRONT,  8'hFF, 32'hFFFF_FFFF);
        send_fixed(REQ_REMOVE,     8'h00, 32'h0000_0000);
        send_fixed(REQ_GET,        8'h00, 32'h0000_0000);
        send_fixed(REQ_SET,        8'h00, 32'h0000_1234);
        send_fixed(REQ_INSERT,     8'h00, 32'h5555_AAAA);
        send_fixed(REQ_PUSH_BACK,  8'hFF, 32'h7FFF_FFFF);
        send_fixed(REQ_PUSH_FRONT, 8'h00, 32'h8000_0000);
        send_fixed(REQ_INSERT,     8'h01, 32'hFFFF_FFFF);
        send_fixed(REQ_INSERT,     8'h03, 32'h0000_0001);
        send_fixed(REQ_GET,        8'h00, 32'h0000_0000);
        send_fixed(REQ_GET,        8'h01, 32'h0000_0000);
        send_fixed(REQ_GET,        8'h02, 32'h0000_0000);
        send_fixed(REQ_GET,        8'h03, 32'h0000_0000);
        send_fixed(REQ_SET,        8'h02, 32'h0000_0000);
        send_fixed(REQ_SET,        8'hFF, 32'hAAAA_5555);
        send_fixed(REQ_REMOVE,     8'h01, 32'h0000_0000);
        send_fixed(REQ_GET,        8'h01, 32'h0000_0000);
        send_fixed(REQ_POP_BACK,   8'h00, 32'h0000_0000);
        send_fixed(REQ_POP_FRONT,  8'h00, 32'h0000_0000);
        send_fixed(REQ_POP_BACK,   8'h00, 32'h0000_0000);
        send_fixed(REQ_PUSH_BACK,  8'h00, 32'h0000_0000);
        send_fixed(REQ_REMOVE,     8'hFF, 32'h0000_0000);
        send_fixed(REQ_REMOVE,     8'h00, 32'h0000_0000);
        sent = 24;
        drain_wait();

        // Random: wander, then fill to capacity while the result side holds
        // off for a long stretch, push against the full list, let everything
        // drain, wander near the top, then empty it and pop against empty.
        repeat (120) begin
            send_random(MIX_ANY);
            sent++;
        end
        hold_sink = 1'b1;
        while (list_len != LIST_CAP) begin
            send_random(MIX_GROW);
            sent++;
        end
        repeat (12) begin
            send_random(MIX_GROW);
            sent++;
        end
        drain_wait();
        repeat (80) begin
            send_random(MIX_ANY);
            sent++;
        end
        while (list_len != 0) begin
            send_random(MIX_SHRINK);
            sent++;
        end
        repeat (12) begin
            send_random(MIX_SHRINK);
            sent++;
        end
        while (sent < ITEMS) begin
            send_random(MIX_ANY);
            sent++;
        end

        // Release the request channel, collect what is owed, then let the
        // block settle so a stray beat would still be caught.
        drain_wait();
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("tb: %0d requests, %0d results in %0d cycles; list length peaked at %0d of %0d",
                 requests_sent, results_taken, cycles_run, peak_len, LIST_CAP);
        $display("tb: refusals seen: %0d full, %0d empty, %0d bad index; %0d mismatches",
                 full_refusals, empty_refusals, index_refusals, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ilir_pkg.sv
rtl/ilir_cell.sv
rtl/indexed_list_insert_remove.sv
bench/indexed_list_checker.sv
bench/tb.sv
